// File: rtl/mtg_pkg.sv
// shared constants, types and the tempering function of the mt19937 generator
package mtg_pkg;

	localparam int TABLE_DEPTH = 624;
	localparam int TWIST_OFFSET = 397;
	localparam int IDX_W = 10;
	localparam int COUNT_W = 7;
	localparam int OFIFO_DEPTH = 4;
	localparam int OFIFO_PTR_W = 2;
	localparam int OFIFO_CNT_W = 3;

	localparam logic [COUNT_W-1:0] MAX_RUN = COUNT_W'(64);
	localparam logic [IDX_W-1:0] IDX_END = IDX_W'(TABLE_DEPTH);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);
	localparam logic [IDX_W:0] FAR_OFS = (IDX_W + 1)'(TWIST_OFFSET);
	localparam logic [IDX_W:0] DEPTH_WIDE = (IDX_W + 1)'(TABLE_DEPTH);

	localparam logic [31:0] RESET_SEED = 32'd4357;
	localparam logic [31:0] FILL_MULT = 32'd69069;
	localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
	localparam logic [31:0] TEMPER_B = 32'h9d2c_5680;
	localparam logic [31:0] TEMPER_C = 32'hefc6_0000;

	typedef enum logic [1:0] {
		ST_FILL,
		ST_GEN,
		ST_TWIST
	} mtg_state_t;

	// request handed from the front queue to the back end
	typedef struct packed {
		logic valid;
		logic [COUNT_W-1:0] count;
	} mtg_job_t;

	function automatic logic [31:0] mtg_temper(input logic [31:0] w);
		logic [31:0] y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

// File: rtl/mtg_if.sv
// valid/ready channel interfaces for requests and generated words
interface mtg_req_if import mtg_pkg::*; ();
	logic valid;
	logic ready;
	logic [COUNT_W-1:0] count;

	modport source (output valid, output count, input ready);
	modport sink (input valid, input count, output ready);
endinterface

interface mtg_rsp_if;
	logic valid;
	logic ready;
	logic [31:0] value;
	logic last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

// File: rtl/mersenne_twister_generator.sv
// top level of the mt19937 random word generator
// req channel: one request carries count, the number of 32-bit words wanted;
// zero is taken and yields nothing, counts above 64 are served as 64.
// rsp channel: one word per response, last marks the final word of a request.
// cfg_we/cfg_wdata: writes the seed and restarts the table fill; only write
// while no request is pending.
// after reset (seed 4357) and after each seed write the 624-word table is
// filled one word per cycle, during which requests are queued (two deep)
// but no words come out.
// an accepted request waits in the front queue; its words pass through the
// table read register and the output queue. each time the table is used up
// (every 624 words, and before the first word after a fill) an in-place
// twist runs, one table entry per cycle over the two read ports.
// outside twists, words come out one per cycle while the receiver keeps up.
// when rsp stalls, a four-entry output queue absorbs words in flight and then
// table reads pause; no word is lost and requests keep queuing in front.
module mersenne_twister_generator import mtg_pkg::*; (
	input logic clk,
	input logic arst_n,
	mtg_req_if.sink req,
	mtg_rsp_if.source rsp,
	input logic cfg_we,
	input logic [31:0] cfg_wdata
);

	mtg_job_t job;
	logic job_pop;

	mtg_front u_front (
		.clk (clk),
		.arst_n (arst_n),
		.req (req),
		.job (job),
		.job_pop (job_pop)
	);

	mtg_back u_back (
		.clk (clk),
		.arst_n (arst_n),
		.cfg_we (cfg_we),
		.cfg_wdata (cfg_wdata),
		.job (job),
		.job_pop (job_pop),
		.rsp (rsp)
	);

endmodule

// File: rtl/mtg_front.sv
// request intake: drops empty requests, clamps counts and queues them
module mtg_front import mtg_pkg::*; (
	input logic clk,
	input logic arst_n,
	mtg_req_if.sink req,
	output mtg_job_t job,
	input logic job_pop
);

	logic [COUNT_W-1:0] q_count_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;
	logic push;
	logic [COUNT_W-1:0] clamped;

	assign req.ready = (cnt_q != 2'd2);
	assign clamped = (req.count > MAX_RUN) ? MAX_RUN : req.count;
	// a request for zero words is taken and forgotten
	assign push = req.valid && req.ready && (req.count != '0);

	assign job.valid = (cnt_q != 2'd0);
	assign job.count = q_count_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (job_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, job_pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_count_q[wr_ptr_q] <= clamped;
		end
	end

endmodule

// File: rtl/mtg_back.sv
// state table, seeding fill, in-place twist, word read-out and output queue
module mtg_back import mtg_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [31:0] cfg_wdata,
	input mtg_job_t job,
	output logic job_pop,
	mtg_rsp_if.source rsp
);

	logic [31:0] mem [TABLE_DEPTH];
	logic [31:0] rd_a_q;
	logic [31:0] rd_b_q;
	logic [IDX_W-1:0] addr_a;
	logic [IDX_W-1:0] addr_b;
	logic we;
	logic [IDX_W-1:0] waddr;
	logic [31:0] wdata;

	mtg_state_t state_q, state_d;
	logic [31:0] fill_q;
	logic [IDX_W-1:0] fill_idx_q;
	logic [IDX_W-1:0] read_index_q;
	logic [COUNT_W-1:0] done_q;

	logic tw_prime_q;
	logic tw_load_q;
	logic [IDX_W-1:0] tw_iss_q;
	logic tw_v_s2_q;
	logic [IDX_W-1:0] tw_k_s2;
	logic [31:0] cur_q;
	logic [IDX_W-1:0] tw_nxt;
	logic [IDX_W:0] far_sum;
	logic [IDX_W-1:0] tw_far;
	logic [31:0] mix_y;
	logic [31:0] twisted;

	logic gen_v_s2_q;
	logic gen_last_s2_q;
	logic issue;
	logic word_last;
	logic credit;

	logic [32:0] ofifo_q [OFIFO_DEPTH];
	logic [OFIFO_PTR_W-1:0] of_wr_q;
	logic [OFIFO_PTR_W-1:0] of_rd_q;
	logic [OFIFO_CNT_W-1:0] of_cnt_q;
	logic of_pop;

	assign tw_nxt = (tw_iss_q == IDX_LAST) ? '0 : tw_iss_q + IDX_W'(1);
	assign far_sum = {1'b0, tw_iss_q} + FAR_OFS;
	assign tw_far = (far_sum >= DEPTH_WIDE) ? IDX_W'(far_sum - DEPTH_WIDE) : far_sum[IDX_W-1:0];

	// upper bit of the current word, lower bits of the next one
	assign mix_y = {cur_q[31], rd_a_q[30:0]};
	assign twisted = rd_b_q ^ (mix_y >> 1) ^ (mix_y[0] ? TWIST_MATRIX : 32'd0);

	assign word_last = ((done_q + COUNT_W'(1)) == job.count);
	assign credit = ((of_cnt_q + OFIFO_CNT_W'(gen_v_s2_q)) < OFIFO_CNT_W'(OFIFO_DEPTH));

	always_comb begin
		state_d = state_q;
		addr_a = read_index_q;
		addr_b = tw_far;
		we = 1'b0;
		waddr = fill_idx_q;
		wdata = fill_q;
		issue = 1'b0;
		job_pop = 1'b0;
		case (state_q)
			ST_FILL: begin
				we = 1'b1;
				if (fill_idx_q == IDX_LAST) begin
					state_d = ST_GEN;
				end
			end
			ST_GEN: begin
				if (job.valid && credit) begin
					if (read_index_q == IDX_END) begin
						state_d = ST_TWIST;
					end else begin
						issue = 1'b1;
						job_pop = word_last;
					end
				end
			end
			ST_TWIST: begin
				addr_a = tw_prime_q ? '0 : tw_nxt;
				if (tw_v_s2_q) begin
					we = 1'b1;
					waddr = tw_k_s2;
					wdata = twisted;
					if (tw_k_s2 == IDX_LAST) begin
						state_d = ST_GEN;
					end
				end
			end
			default: state_d = ST_FILL;
		endcase
		if (cfg_we) begin
			state_d = ST_FILL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			fill_q <= RESET_SEED;
			fill_idx_q <= '0;
			read_index_q <= IDX_END;
			done_q <= '0;
			tw_prime_q <= 1'b0;
			tw_load_q <= 1'b0;
			tw_iss_q <= '0;
			tw_v_s2_q <= 1'b0;
			gen_v_s2_q <= 1'b0;
		end else begin
			state_q <= state_d;
			gen_v_s2_q <= issue;
			if (cfg_we) begin
				fill_q <= cfg_wdata;
				fill_idx_q <= '0;
				read_index_q <= IDX_END;
				done_q <= '0;
				tw_v_s2_q <= 1'b0;
				tw_prime_q <= 1'b0;
				tw_load_q <= 1'b0;
			end else begin
				case (state_q)
					ST_FILL: begin
						fill_q <= 32'(fill_q * FILL_MULT);
						fill_idx_q <= fill_idx_q + IDX_W'(1);
					end
					ST_GEN: begin
						if (state_d == ST_TWIST) begin
							tw_prime_q <= 1'b1;
							tw_load_q <= 1'b0;
							tw_iss_q <= '0;
							tw_v_s2_q <= 1'b0;
						end
						if (issue) begin
							read_index_q <= read_index_q + IDX_W'(1);
							done_q <= word_last ? '0 : done_q + COUNT_W'(1);
						end
					end
					ST_TWIST: begin
						tw_prime_q <= 1'b0;
						tw_load_q <= tw_prime_q;
						if (!tw_prime_q && tw_iss_q != IDX_END) begin
							tw_v_s2_q <= 1'b1;
							tw_iss_q <= tw_iss_q + IDX_W'(1);
						end else begin
							tw_v_s2_q <= 1'b0;
						end
						if (tw_v_s2_q && tw_k_s2 == IDX_LAST) begin
							read_index_q <= '0;
						end
					end
					default: begin
						fill_idx_q <= '0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_a_q <= mem[addr_a];
		rd_b_q <= mem[addr_b];
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		gen_last_s2_q <= word_last;
		tw_k_s2 <= tw_iss_q;
		// the word read for one step is the current word of the next step
		if (tw_load_q || tw_v_s2_q) begin
			cur_q <= rd_a_q;
		end
	end

	// output queue; reads are only issued when a slot is sure to be free
	assign of_pop = rsp.valid && rsp.ready;
	assign rsp.valid = (of_cnt_q != '0);
	assign rsp.value = ofifo_q[of_rd_q][31:0];
	assign rsp.last = ofifo_q[of_rd_q][32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			of_wr_q <= '0;
			of_rd_q <= '0;
			of_cnt_q <= '0;
		end else begin
			if (gen_v_s2_q) begin
				of_wr_q <= of_wr_q + OFIFO_PTR_W'(1);
			end
			if (of_pop) begin
				of_rd_q <= of_rd_q + OFIFO_PTR_W'(1);
			end
			case ({gen_v_s2_q, of_pop})
				2'b10: of_cnt_q <= of_cnt_q + OFIFO_CNT_W'(1);
				2'b01: of_cnt_q <= of_cnt_q - OFIFO_CNT_W'(1);
				default: of_cnt_q <= of_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (gen_v_s2_q) begin
			ofifo_q[of_wr_q] <= {gen_last_s2_q, mtg_temper(rd_a_q)};
		end
	end

endmodule

// File: test/testbench.sv
// testbench of the mt19937 generator: scoreboard prediction, bursty requests, stalled responses
`timescale 1ns / 100ps

module testbench import mtg_pkg::*;;

	localparam int IDLE_LIMIT = 6000;
	localparam int SETTLE_CYCLES = 20;

	typedef struct packed {
		logic [31:0] value;
		logic last;
	} mt_word_t;

	class mt_scoreboard;
		logic [31:0] words [TABLE_DEPTH];
		int unsigned word_pos;
		mt_word_t expected_words[$];
		int errors;

		function new();
			errors = 0;
			reseed(RESET_SEED);
		endfunction

		function void reseed(input logic [31:0] s);
			words[0] = s;
			for (int i = 1; i < TABLE_DEPTH; i++)
				words[i] = words[i-1] * FILL_MULT;
			word_pos = TABLE_DEPTH;
		endfunction

		function void regenerate();
			logic [31:0] y;
			int nxt;
			int far;
			for (int k = 0; k < TABLE_DEPTH; k++) begin
				nxt = (k + 1) % TABLE_DEPTH;
				far = (k + TWIST_OFFSET) % TABLE_DEPTH;
				y = {words[k][31], words[nxt][30:0]};
				words[k] = words[far] ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : 32'd0);
			end
			word_pos = 0;
		endfunction

		function logic [31:0] tempered(input logic [31:0] w);
			logic [31:0] t;
			t = w ^ (w >> 11);
			t = t ^ ((t << 7) & TEMPER_B);
			t = t ^ ((t << 15) & TEMPER_C);
			return t ^ (t >> 18);
		endfunction

		function void note_request(input logic [COUNT_W-1:0] cnt);
			int run;
			mt_word_t w;
			run = (cnt > MAX_RUN) ? int'(MAX_RUN) : int'(cnt);
			for (int k = 0; k < run; k++) begin
				if (word_pos >= TABLE_DEPTH)
					regenerate();
				w.value = tempered(words[word_pos]);
				w.last = (k == run - 1);
				expected_words.push_back(w);
				word_pos++;
			end
		endfunction

		function void check_word(input logic [31:0] value, input logic last);
			mt_word_t w;
			if (expected_words.size() == 0) begin
				$error("unexpected word: value %h last %b", value, last);
				errors++;
				return;
			end
			w = expected_words.pop_front();
			if (value !== w.value) begin
				$error("value: expected %h, got %h", w.value, value);
				errors++;
			end
			if (last !== w.last) begin
				$error("last: expected %b, got %b", w.last, last);
				errors++;
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [31:0] cfg_wdata;

	mtg_req_if req();
	mtg_rsp_if rsp();

	mt_scoreboard sb;
	int burst_left = 0;
	int ready_hold = 0;
	int idle_cycles = 0;

	mersenne_twister_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// request and word monitors
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				sb.note_request(req.count);
			if (rsp.valid && rsp.ready)
				sb.check_word(rsp.value, rsp.last);
		end
	end

	// receiver: short stalls, free runs of varying length
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b1;
			ready_hold <= 0;
		end else if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else if (rsp.ready) begin
			rsp.ready <= 1'b0;
			ready_hold <= $urandom_range(0, 7);
		end else begin
			rsp.ready <= 1'b1;
			ready_hold <= ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
				: $urandom_range(0, 15);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic send_request(input logic [COUNT_W-1:0] cnt);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
			if (gap != 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		req.valid <= 1'b1;
		req.count <= cnt;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		burst_left--;
	endtask

	function automatic logic [COUNT_W-1:0] random_count();
		int pick;
		pick = $urandom_range(0, 19);
		case (pick)
			0: return '0;
			1: return COUNT_W'($urandom_range(65, 127));
			2, 3, 4: return COUNT_W'($urandom_range(1, 4));
			5: return MAX_RUN;
			default: return COUNT_W'($urandom_range(1, 64));
		endcase
	endfunction

	task automatic run_random(input int n);
		for (int i = 0; i < n; i++)
			send_request(random_count());
	endtask

	task automatic drain_requests();
		req.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// seed writes only with the block idle; zero-count requests leave nothing in flight
	task automatic load_seed(input logic [31:0] s);
		drain_requests();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= s;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.reseed(s);
	endtask

	initial begin
		logic [COUNT_W-1:0] directed_counts [12];
		directed_counts = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd2, 7'd63, 7'd100,
			7'd0, 7'd32, 7'd1, 7'd64};
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.count = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_counts[i])
			send_request(directed_counts[i]);
		run_random(80);

		load_seed(32'd0);
		run_random(30);
		load_seed(32'hffff_ffff);
		run_random(60);
		load_seed($urandom);
		run_random(140);

		drain_requests();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
